// ===== src/sync_word_frame_receiver_assert.svh =====
// Assertion macros used by the sync word frame receiver RTL.
`ifndef SYNC_WORD_FRAME_RECEIVER_ASSERT_SVH
`define SYNC_WORD_FRAME_RECEIVER_ASSERT_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define SWFR_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define SWFR_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== src/swfr_pkg.sv =====
// Types, constants and codes of the sync word frame receiver.
package swfr_pkg;

  localparam int unsigned PAYLOAD_BYTES_DEF = 32;
  localparam int unsigned SYNC_LEN          = 4;
  localparam int unsigned FRAME_WORDS       = 8;
  localparam int unsigned FRAME_BYTES       = 4 * FRAME_WORDS;
  localparam int unsigned CFG_DATA_W        = 16;
  localparam int unsigned CFG_IDX_W         = 1;

  localparam logic [15:0] POLL_BUDGET_RST = 16'd1000;
  localparam logic [3:0]  FAIL_LIMIT_RST  = 4'd7;

  localparam logic [7:0] SYNC_WORD [SYNC_LEN] = '{8'h54, 8'h53, 8'h43, 8'h48};

  typedef enum logic [1:0] {
    ST_COMPLETE = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_LOST     = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLL_BUDGET = 1'b0,
    CFG_FAIL_LIMIT  = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_POLL = 1'b1
  } kind_t;

endpackage

// ===== src/swfr_in_if.sv =====
// Input event channel: one received byte or one empty poll per transfer.
interface swfr_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

// ===== src/swfr_out_if.sv =====
// Result channel: one frame or failure report per transfer.
interface swfr_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [31:0]        timestamp;
  logic signed [31:0] quat_w;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  logic signed [31:0] gyro_x;
  logic signed [31:0] gyro_y;
  logic signed [31:0] gyro_z;

  modport source (output valid, output status, output timestamp, output quat_w,
                  output quat_x, output quat_y, output quat_z, output gyro_x,
                  output gyro_y, output gyro_z, input ready);
  modport sink (input valid, input status, input timestamp, input quat_w,
                input quat_x, input quat_y, input quat_z, input gyro_x,
                input gyro_y, input gyro_z, output ready);
endinterface

// ===== src/sync_word_frame_receiver.sv =====
// Top level of the sync word frame receiver: sync hunt, payload capture, timeouts.
//
//   port      direction  what one transfer carries
//   in_ch     sink       kind (byte or empty poll), rx_byte
//   out_ch    source     status, timestamp, quat_w/x/y/z, gyro_x/y/z
//   cfg_*     write      cfg_idx selects poll_budget or fail_limit
//
// One input transfer is taken per cycle unless stalled; all its work is done in
// that cycle and any result sits in the output register from the next cycle on.
// in_ch.ready is low only while a result waits and out_ch.ready is low.
// rst_n is synchronous: poll budget returns to 1000, fail limit to 7, and the
// sync hunt, payload count, poll counter and fail count restart.
module sync_word_frame_receiver
  import swfr_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  swfr_in_if.sink               in_ch,
  swfr_out_if.source            out_ch
);

  localparam int unsigned CNT_W   = $clog2(PAYLOAD_BYTES);
  localparam int unsigned SHIFT_N = PAYLOAD_BYTES - 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PAYLOAD_BYTES - 1);
  localparam logic [2:0]       SYNC_DONE = 3'(SYNC_LEN);

  logic [15:0]      poll_budget_r;
  logic [3:0]       fail_limit_r;
  logic [2:0]       sync_matched_r, sync_matched_nxt;
  logic [CNT_W-1:0] payload_count_r, payload_count_nxt;
  logic [15:0]      polls_left_r, polls_left_nxt;
  logic [3:0]       failed_frames_r, failed_frames_nxt;
  logic [7:0]       shift_r [SHIFT_N];

  logic             out_valid_r;
  status_t          status_r, status_nxt;
  logic [31:0]      word_r [FRAME_WORDS];
  logic [31:0]      word_nxt [FRAME_WORDS];

  logic             in_fire;
  logic             out_load;
  logic             is_poll;
  logic             synced;
  logic             take_byte;
  logic [4:0]       fail_inc;
  logic [7:0]       frame_byte [FRAME_BYTES];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_poll     = (in_ch.kind == KIND_POLL);
  assign synced      = (sync_matched_r == SYNC_DONE);
  assign take_byte   = in_fire && !is_poll && synced;
  assign fail_inc    = {1'b0, failed_frames_r} + 5'd1;

  // Byte k of the finished frame: earlier bytes come from the shift line, the
  // last one is the byte of this transfer, and bytes past the payload read 0.
  for (genvar k = 0; k < FRAME_BYTES; k++) begin : g_frame
    if (k < SHIFT_N) begin : g_old
      assign frame_byte[k] = shift_r[k];
    end else if (k == SHIFT_N) begin : g_new
      assign frame_byte[k] = in_ch.rx_byte;
    end else begin : g_pad
      assign frame_byte[k] = 8'h00;
    end
  end

  always_comb begin
    sync_matched_nxt  = sync_matched_r;
    payload_count_nxt = payload_count_r;
    polls_left_nxt    = polls_left_r;
    failed_frames_nxt = failed_frames_r;
    status_nxt        = ST_COMPLETE;
    out_load          = 1'b0;
    for (int w = 0; w < FRAME_WORDS; w++) begin
      word_nxt[w] = 32'd0;
    end
    if (in_fire) begin
      if (is_poll) begin
        if (polls_left_r > 16'd1) begin
          polls_left_nxt = polls_left_r - 16'd1;
        end else begin
          out_load = 1'b1;
          if (fail_inc > {1'b0, fail_limit_r}) begin
            status_nxt        = ST_LOST;
            failed_frames_nxt = 4'd0;
          end else begin
            status_nxt        = ST_TIMEOUT;
            failed_frames_nxt = fail_inc[3:0];
          end
        end
      end else if (!synced) begin
        if (in_ch.rx_byte == SYNC_WORD[sync_matched_r[1:0]]) begin
          sync_matched_nxt = sync_matched_r + 3'd1;
        end else if (in_ch.rx_byte == SYNC_WORD[0]) begin
          sync_matched_nxt = 3'd1;
        end else begin
          sync_matched_nxt = 3'd0;
        end
      end else if (payload_count_r == LAST_CNT) begin
        out_load          = 1'b1;
        status_nxt        = ST_COMPLETE;
        failed_frames_nxt = 4'd0;
        for (int w = 0; w < FRAME_WORDS; w++) begin
          word_nxt[w] = {frame_byte[4*w+3], frame_byte[4*w+2],
                         frame_byte[4*w+1], frame_byte[4*w]};
        end
      end else begin
        payload_count_nxt = payload_count_r + CNT_W'(1);
      end
      // Any result starts the next frame afresh.
      if (out_load) begin
        sync_matched_nxt  = 3'd0;
        payload_count_nxt = '0;
        polls_left_nxt    = poll_budget_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_budget_r   <= POLL_BUDGET_RST;
      fail_limit_r    <= FAIL_LIMIT_RST;
      sync_matched_r  <= 3'd0;
      payload_count_r <= '0;
      polls_left_r    <= POLL_BUDGET_RST;
      failed_frames_r <= 4'd0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_POLL_BUDGET: poll_budget_r <= cfg_wdata[15:0];
          CFG_FAIL_LIMIT:  fail_limit_r  <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      sync_matched_r  <= sync_matched_nxt;
      payload_count_r <= payload_count_nxt;
      polls_left_r    <= polls_left_nxt;
      failed_frames_r <= failed_frames_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload bytes march down a shift line, so byte k sits in a fixed place at
  // the end of the frame.
  always_ff @(posedge clk) begin
    if (take_byte) begin
      shift_r[SHIFT_N-1] <= in_ch.rx_byte;
      for (int i = 0; i < SHIFT_N - 1; i++) begin
        shift_r[i] <= shift_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status_r <= status_nxt;
      for (int w = 0; w < FRAME_WORDS; w++) begin
        word_r[w] <= word_nxt[w];
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = status_r;
  assign out_ch.timestamp = word_r[0];
  assign out_ch.quat_w    = word_r[1];
  assign out_ch.quat_x    = word_r[2];
  assign out_ch.quat_y    = word_r[3];
  assign out_ch.quat_z    = word_r[4];
  assign out_ch.gyro_x    = word_r[5];
  assign out_ch.gyro_y    = word_r[6];
  assign out_ch.gyro_z    = word_r[7];

  `include "sync_word_frame_receiver_assert.svh"

  `SWFR_ASSERT_NOW(a_sync_range, 1'b1, sync_matched_r <= SYNC_DONE, "sync count out of range")
  `SWFR_ASSERT_NOW(a_count_needs_sync, payload_count_r != '0, synced,
                   "payload counted without sync")
  `SWFR_ASSERT_NOW(a_stall_only_on_result, !in_ch.ready, out_valid_r,
                   "input stalled without a waiting result")
  `SWFR_ASSERT_NEXT(a_lost_clears, out_load && status_nxt == ST_LOST,
                    failed_frames_r == 4'd0, "fail count kept after device loss")
  `SWFR_ASSERT_NEXT(a_result_restarts, out_load,
                    sync_matched_r == 3'd0 && payload_count_r == '0 && out_valid_r,
                    "frame not restarted after a result")

endmodule
